// ===== hw/rtl/ptad_pkg.sv =====
package ptad_pkg;

   // number of ports that have a stored counter pair
   localparam int PORTS = 8;
   localparam int PORT_IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

   localparam int PORT_W = 3;
   localparam int CNT_W = 32;
   localparam int MASK_W = 8;
   localparam int COUNTED_W = 4;
   localparam logic [COUNTED_W-1:0] COUNTED_MAX = '1;

   // request tdata: port, rx_count, tx_count, zero fill to whole bytes
   localparam int REQ_DATA_BITS = PORT_W + 2 * CNT_W;
   localparam int REQ_DATA_W = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      CMD_CHECK = 1'b0,
      CMD_RESET = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WATCH_MASK     = 1'b0,
      CSR_BYTE_THRESHOLD = 1'b1
   } csr_idx_type;

   typedef struct packed {
      cmd_type            command;
      logic [PORT_W-1:0]  port;
      logic [CNT_W-1:0]   rx_count;
      logic [CNT_W-1:0]   tx_count;
      logic               scan_end;
   } item_type;

   typedef struct packed {
      logic active;
      logic no_ports_counted;
   } result_type;

endpackage

// ===== hw/rtl/port_traffic_activity_detector.sv =====
// port traffic activity detector
// one request transfer carries one byte-counter sample of a switch port together
// with a command: check (compare against the stored pair and sum the deltas) or
// reset (reload the stored pair, zero for an unwatched port). tlast marks the last sample of a scan.
// a check transfer with tlast produces one response transfer: active when the
// saturated delta sum reached byte_threshold, no_ports_counted when no port
// contributed. all other requests produce no response.
// path: an accepted request sits in the input register, is worked on as it
// leaves it, and a check with tlast loads its response into the result register.
// throughput: one request per cycle unless a scan-ending request waits for the
// response slot; store read, delta add and threshold compare sit between the two.
// the result register lets new requests flow while a response waits; when the
// receiver stalls, check requests without tlast and reset commands still pass,
// and a scan-ending request holds in the input register until the response slot
// frees, which then back-pressures req_tready.
// reset (synchronous) clears the stored counter pairs, the sum, the port count,
// the watch mask and byte_threshold, and empties both registers.
// csr writes are registered and are expected only while the block is idle.
module port_traffic_activity_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ptad_pkg::REQ_DATA_W-1:0]      req_tdata,  // port, rx_count, tx_count, zero fill
   input  logic                                 req_tlast,  // scan_end
   input  logic                                 req_tuser,  // command
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ptad_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // active, no_ports_counted, zero fill
   // register write port
   input  logic                                 csr_we,
   input  logic [ptad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptad_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ptad_pkg::*;

   // handoff between the stages
   logic       item_valid;
   item_type   item;
   logic       advance;
   logic       out_ready;
   logic       result_load;
   result_type result;

   // input register, takes a transfer whenever it is free or draining
   ptad_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // counter store, delta sum and registers
   ptad_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_valid  (item_valid),
      .item        (item),
      .out_ready   (out_ready),
      .advance     (advance),
      .result_load (result_load),
      .result      (result)
   );

   // response register
   ptad_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .out_ready   (out_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== hw/rtl/ptad_in_stage.sv =====
module ptad_in_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ptad_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 req_tuser,
   input  logic                                 advance,
   output logic                                 item_valid,
   output ptad_pkg::item_type                   item
);
   import ptad_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     take;

   // register frees up when empty or when the held item moves on
   assign req_tready = !valid_ff || advance;
   assign take = req_tvalid && req_tready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      item_in.command = cmd_type'(req_tuser);
      item_in.port = req_tdata[PORT_W-1:0];
      item_in.rx_count = req_tdata[PORT_W +: CNT_W];
      item_in.tx_count = req_tdata[PORT_W+CNT_W +: CNT_W];
      item_in.scan_end = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// ===== hw/rtl/ptad_core.sv =====
module ptad_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ptad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptad_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 item_valid,
   input  ptad_pkg::item_type                   item,
   input  logic                                 out_ready,
   output logic                                 advance,
   output logic                                 result_load,
   output ptad_pkg::result_type                 result
);
   import ptad_pkg::*;

   logic [MASK_W-1:0]    watch_mask_ff;
   logic [CNT_W-1:0]     threshold_ff;
   logic [CNT_W-1:0]     prev_rx_ff [PORTS];
   logic [CNT_W-1:0]     prev_tx_ff [PORTS];
   logic [CNT_W-1:0]     delta_sum_ff;
   logic [CNT_W-1:0]     delta_sum_in;
   logic [COUNTED_W-1:0] counted_ff;
   logic [COUNTED_W-1:0] counted_in;

   logic                  in_range;
   logic                  watched;
   logic [PORT_IDX_W-1:0] idx;
   logic [CNT_W-1:0]      prev_rx;
   logic [CNT_W-1:0]      prev_tx;
   logic                  prev_zero;
   logic [CNT_W-1:0]      d_rx;
   logic [CNT_W-1:0]      d_tx;
   logic [CNT_W+1:0]      sum_wide;
   logic [CNT_W-1:0]      sum_sat;
   logic                  is_check;
   logic                  ends_scan;
   logic                  fire;
   logic                  do_count;
   logic                  store_wr;
   logic [CNT_W-1:0]      store_rx;
   logic [CNT_W-1:0]      store_tx;

   always_comb begin
      in_range = (32'(item.port) < 32'(PORTS));
      watched = in_range && watch_mask_ff[item.port];
      idx = PORT_IDX_W'(item.port);
      prev_rx = prev_rx_ff[idx];
      prev_tx = prev_tx_ff[idx];
      prev_zero = (prev_rx == '0) && (prev_tx == '0);
      is_check = (item.command == CMD_CHECK);
      ends_scan = is_check && item.scan_end;

      // an item with a result waits for space in the result register
      advance = item_valid && (!ends_scan || out_ready);
      fire = advance;

      // wrap-aware deltas, saturating sum
      d_rx = item.rx_count - prev_rx;
      d_tx = item.tx_count - prev_tx;
      sum_wide = {2'b00, delta_sum_ff} + {2'b00, d_rx} + {2'b00, d_tx};
      sum_sat = (sum_wide[CNT_W+1:CNT_W] != 2'b00) ? '1 : sum_wide[CNT_W-1:0];

      do_count = fire && is_check && watched && !prev_zero;

      delta_sum_in = delta_sum_ff;
      counted_in = counted_ff;
      if (do_count) begin
         delta_sum_in = sum_sat;
         if (counted_ff != COUNTED_MAX) begin
            counted_in = counted_ff + 1'b1;
         end
      end

      result.active = (delta_sum_in >= threshold_ff);
      result.no_ports_counted = (counted_in == '0);
      result_load = fire && ends_scan;

      // store update: check on watched port, or reset command on any stored port
      store_wr = fire && in_range && (watched || !is_check);
      store_rx = watched ? item.rx_count : '0;
      store_tx = watched ? item.tx_count : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         watch_mask_ff <= '0;
         threshold_ff <= '0;
         delta_sum_ff <= '0;
         counted_ff <= '0;
         for (int i = 0; i < PORTS; i++) begin
            prev_rx_ff[i] <= '0;
            prev_tx_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_WATCH_MASK: watch_mask_ff <= csr_wdata[MASK_W-1:0];
               CSR_BYTE_THRESHOLD: threshold_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (result_load) begin
            delta_sum_ff <= '0;
            counted_ff <= '0;
         end else begin
            delta_sum_ff <= delta_sum_in;
            counted_ff <= counted_in;
         end
         if (store_wr) begin
            prev_rx_ff[idx] <= store_rx;
            prev_tx_ff[idx] <= store_tx;
         end
      end
   end

   // scan totals start over after each reported scan
   assert property (@(posedge clock) disable iff (reset)
      result_load |=> (delta_sum_ff == '0) && (counted_ff == '0))
      else $error("scan totals not cleared after result");

   // a reset command leaves the scan totals alone
   assert property (@(posedge clock) disable iff (reset)
      (fire && !is_check) |=> $stable(delta_sum_ff) && $stable(counted_ff))
      else $error("reset command changed scan totals");

   // nothing is summed without a counted port
   assert property (@(posedge clock) disable iff (reset)
      (counted_ff == '0) |-> (delta_sum_ff == '0))
      else $error("delta sum set with no counted port");

endmodule

// ===== hw/rtl/ptad_out_stage.sv =====
module ptad_out_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 result_load,
   input  ptad_pkg::result_type                 result,
   output logic                                 out_ready,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ptad_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import ptad_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = result_load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (result_load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W-2){1'b0}}, result_ff.no_ports_counted, result_ff.active};

endmodule
